// ----- design/bwt_pkg.sv -----
package bwt_pkg;

  localparam int BANK_BYTES_DEF = 16;
  localparam int WAVE_BASE      = 32;

  // input commands
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_LEN   = 2'd3
  } cmd_t;

  // control byte offsets
  localparam logic [5:0] ADDR_CTRL_LO = 6'd0;
  localparam logic [5:0] ADDR_LEN_LO  = 6'd2;
  localparam logic [5:0] ADDR_LEN_HI  = 6'd3;
  localparam logic [5:0] ADDR_FREQ_LO = 6'd4;
  localparam logic [5:0] ADDR_FREQ_HI = 6'd5;

  // read-back masks
  localparam logic [7:0] MASK_CTRL_LO = 8'hE0;
  localparam logic [7:0] MASK_LEN_HI  = 8'hE0;
  localparam logic [7:0] MASK_FREQ_HI = 8'h40;

  // volume codes
  localparam logic [1:0] VOL_MUTE    = 2'd0;
  localparam logic [1:0] VOL_FULL    = 2'd1;
  localparam logic [1:0] VOL_HALF    = 2'd2;
  localparam logic [1:0] VOL_QUARTER = 2'd3;

  localparam int LEN_W    = 9;
  localparam int PERIOD_W = 15;

  // control stage to output stage
  typedef struct packed {
    logic       rd_wave;
    logic [7:0] ctrl_rdata;
    logic       play;
    logic       nib_lo;
    logic [1:0] vol;
    logic       clear;
    logic       playing;
  } bwt_info_t;

  // (2048 - freq) * 8 ticks
  function automatic logic [PERIOD_W-1:0] period_reload(input logic [10:0] freq);
    logic [11:0] span;
    span = 12'd2048 - {1'b0, freq};
    return PERIOD_W'({span, 3'b000});
  endfunction

endpackage

// ----- design/bwt_if.sv -----
interface bwt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [5:0] addr;
  logic [7:0] wdata;

  modport source (output valid, cmd, addr, wdata, input ready);
  modport sink   (input valid, cmd, addr, wdata, output ready);
endinterface

interface bwt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic [7:0] level;
  logic       active;

  modport source (output valid, rdata, level, active, input ready);
  modport sink   (input valid, rdata, level, active, output ready);
endinterface

// ----- design/bwt_wave_ram.sv -----
module bwt_wave_ram #(
  parameter int MEM_AW = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [MEM_AW-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [MEM_AW-1:0] raddr,
  output logic [7:0]        rdata
);

  localparam int DEPTH = 1 << MEM_AW;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]       rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= vld_r[raddr] ? mem[raddr] : 8'd0;
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/bwt_ctrl.sv -----
module bwt_ctrl #(
  parameter int BANK_BYTES = bwt_pkg::BANK_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [1:0]                   cmd,
  input  logic [5:0]                   addr,
  input  logic [7:0]                   wdata,
  output logic                         mem_we,
  output logic [$clog2(BANK_BYTES):0]  mem_waddr,
  output logic                         mem_re,
  output logic [$clog2(BANK_BYTES):0]  mem_raddr,
  output bwt_pkg::bwt_info_t           info
);

  localparam int BANK_AW = $clog2(BANK_BYTES);
  localparam int NIB_W   = BANK_AW + 1;

  logic [7:0]                   ctrl_lo_r, ctrl_lo_nxt;
  logic [15:0]                  lenvol_r, lenvol_nxt;
  logic [15:0]                  freq_r, freq_nxt;
  logic                         playing_r, playing_nxt;
  logic                         bank_r, bank_nxt;
  logic                         two_bank_r, two_bank_nxt;
  logic                         may_en_r, may_en_nxt;
  logic [bwt_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic                         len_on_r, len_on_nxt;
  logic [bwt_pkg::PERIOD_W-1:0] period_r, period_nxt;
  logic [NIB_W-1:0]             nib_r, nib_nxt;
  logic [1:0]                   vol_r, vol_nxt;

  logic                         is_wave;
  logic [5:0]                   woff;
  logic [bwt_pkg::LEN_W-1:0]    len_dec;

  assign woff    = addr - 6'(bwt_pkg::WAVE_BASE);
  assign is_wave = ({1'b0, addr} >= 7'(bwt_pkg::WAVE_BASE)) &&
                   ({1'b0, addr} < 7'(bwt_pkg::WAVE_BASE + BANK_BYTES));
  assign len_dec = (len_r != '0) ? len_r - 1'b1 : len_r;

  always_comb begin
    ctrl_lo_nxt  = ctrl_lo_r;
    lenvol_nxt   = lenvol_r;
    freq_nxt     = freq_r;
    playing_nxt  = playing_r;
    bank_nxt     = bank_r;
    two_bank_nxt = two_bank_r;
    may_en_nxt   = may_en_r;
    len_nxt      = len_r;
    len_on_nxt   = len_on_r;
    period_nxt   = period_r;
    nib_nxt      = nib_r;
    vol_nxt      = vol_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = {~bank_r, woff[BANK_AW-1:0]};
    mem_raddr    = {~bank_r, woff[BANK_AW-1:0]};
    info         = '0;

    if (accept) begin
      unique case (bwt_pkg::cmd_t'(cmd))
        bwt_pkg::CMD_TICK: begin
          if (playing_r) begin
            if (period_r <= bwt_pkg::PERIOD_W'(1)) begin
              period_nxt  = bwt_pkg::period_reload(freq_r[10:0]);
              mem_re      = 1'b1;
              mem_raddr   = {bank_r, nib_r[NIB_W-1:1]};
              info.play   = 1'b1;
              info.nib_lo = nib_r[0];
              info.vol    = vol_r;
              nib_nxt     = nib_r + 1'b1;
              // in two-bank mode, the bank flips when the index wraps
              if (nib_nxt == '0 && two_bank_r) begin
                bank_nxt = ~bank_r;
              end
            end else begin
              period_nxt = period_r - 1'b1;
            end
          end
        end
        bwt_pkg::CMD_WRITE: begin
          if (is_wave) begin
            mem_we = 1'b1;
          end else begin
            unique case (addr)
              bwt_pkg::ADDR_CTRL_LO: begin
                ctrl_lo_nxt  = wdata;
                two_bank_nxt = wdata[5];
                bank_nxt     = wdata[6];
                may_en_nxt   = wdata[7];
                if (!wdata[7]) begin
                  playing_nxt = 1'b0;
                  info.clear  = 1'b1;
                end
              end
              bwt_pkg::ADDR_LEN_LO: lenvol_nxt[7:0] = wdata;
              bwt_pkg::ADDR_LEN_HI: begin
                lenvol_nxt[15:8] = wdata;
                len_nxt = 9'd256 - {1'b0, lenvol_r[7:0]};
                vol_nxt = wdata[7] ? bwt_pkg::VOL_FULL : wdata[6:5];
              end
              bwt_pkg::ADDR_FREQ_LO: freq_nxt[7:0] = wdata;
              bwt_pkg::ADDR_FREQ_HI: begin
                freq_nxt[15:8] = wdata;
                // trigger
                if (wdata[7] && may_en_r) begin
                  playing_nxt = 1'b1;
                  if (len_r == '0) begin
                    len_nxt = 9'd256;
                  end
                  period_nxt = bwt_pkg::period_reload({wdata[2:0], freq_r[7:0]});
                  nib_nxt    = '0;
                  bank_nxt   = ctrl_lo_r[6];
                  len_on_nxt = wdata[6];
                end
              end
              default: ;
            endcase
          end
        end
        bwt_pkg::CMD_READ: begin
          if (is_wave) begin
            mem_re       = 1'b1;
            info.rd_wave = 1'b1;
          end else begin
            unique case (addr)
              bwt_pkg::ADDR_CTRL_LO: info.ctrl_rdata = ctrl_lo_r & bwt_pkg::MASK_CTRL_LO;
              bwt_pkg::ADDR_LEN_HI:  info.ctrl_rdata = lenvol_r[15:8] & bwt_pkg::MASK_LEN_HI;
              bwt_pkg::ADDR_FREQ_HI: info.ctrl_rdata = freq_r[15:8] & bwt_pkg::MASK_FREQ_HI;
              default:               info.ctrl_rdata = 8'd0;
            endcase
          end
        end
        bwt_pkg::CMD_LEN: begin
          if (len_on_r) begin
            len_nxt = len_dec;
            if (len_dec == '0) begin
              playing_nxt = 1'b0;
              info.clear  = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    info.playing = playing_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_lo_r  <= '0;
      lenvol_r   <= '0;
      freq_r     <= '0;
      playing_r  <= 1'b0;
      bank_r     <= 1'b0;
      two_bank_r <= 1'b0;
      may_en_r   <= 1'b0;
      len_r      <= '0;
      len_on_r   <= 1'b0;
      period_r   <= '0;
      nib_r      <= '0;
      vol_r      <= bwt_pkg::VOL_MUTE;
    end else begin
      ctrl_lo_r  <= ctrl_lo_nxt;
      lenvol_r   <= lenvol_nxt;
      freq_r     <= freq_nxt;
      playing_r  <= playing_nxt;
      bank_r     <= bank_nxt;
      two_bank_r <= two_bank_nxt;
      may_en_r   <= may_en_nxt;
      len_r      <= len_nxt;
      len_on_r   <= len_on_nxt;
      period_r   <= period_nxt;
      nib_r      <= nib_nxt;
      vol_r      <= vol_nxt;
    end
  end

endmodule

// ----- design/bwt_out.sv -----
module bwt_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  bwt_pkg::bwt_info_t info_in,
  input  logic [7:0]         mem_rdata,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         rdata,
  output logic [7:0]         level,
  output logic               active
);

  bwt_pkg::bwt_info_t info_r;
  logic               vld_r, vld_nxt;
  logic [7:0]         lvl_r;
  logic [7:0]         lvl_new;
  logic [3:0]         nib;
  logic [3:0]         scaled;
  logic               fire;

  assign fire    = vld_r && out_ready;
  assign vld_nxt = load ? 1'b1 : (fire ? 1'b0 : vld_r);

  assign nib = info_r.nib_lo ? mem_rdata[3:0] : mem_rdata[7:4];

  always_comb begin
    case (info_r.vol)
      bwt_pkg::VOL_MUTE:    scaled = 4'd0;
      bwt_pkg::VOL_FULL:    scaled = nib;
      bwt_pkg::VOL_HALF:    scaled = nib >> 1;
      bwt_pkg::VOL_QUARTER: scaled = nib >> 2;
      default:              scaled = 4'd0;
    endcase
  end

  always_comb begin
    if (info_r.clear) begin
      lvl_new = 8'd0;
    end else if (info_r.play) begin
      lvl_new = {scaled, 4'b0000};
    end else begin
      lvl_new = lvl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      lvl_r <= 8'd0;
    end else begin
      vld_r <= vld_nxt;
      if (fire) begin
        lvl_r <= lvl_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      info_r <= info_in;
    end
  end

  assign out_valid = vld_r;
  assign rdata     = info_r.rd_wave ? mem_rdata : info_r.ctrl_rdata;
  assign level     = info_r.playing ? lvl_new : 8'd0;
  assign active    = info_r.playing;

endmodule

// ----- design/banked_wave_table_channel.sv -----
// result: an item's result is registered and offered in the cycle after it is accepted
// throughput: one item per cycle while results drain; the wave memory has one write
//   and one read port, and each item uses at most one of them, so items stream back to back
// reset: synchronous active-low rst_n clears all control state and the wave
//   memory valid bits, so unwritten wave bytes read as zero with no clearing pass
module banked_wave_table_channel #(
  parameter int BANK_BYTES = bwt_pkg::BANK_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bwt_in_if.sink     in_ch,
  bwt_out_if.source  out_ch
);

  // two banks of wave bytes
  localparam int MEM_AW = $clog2(BANK_BYTES) + 1;

  logic               accept;
  logic               mem_we;
  logic               mem_re;
  logic [MEM_AW-1:0]  mem_waddr;
  logic [MEM_AW-1:0]  mem_raddr;
  logic [7:0]         mem_rdata;
  bwt_pkg::bwt_info_t info;

  // take a new item whenever the output slot is empty or being drained
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // control registers, timer, length counter and wave addressing;
  // all updates for an item happen at its accept edge
  bwt_ctrl #(
    .BANK_BYTES (BANK_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cmd       (in_ch.cmd),
    .addr      (in_ch.addr),
    .wdata     (in_ch.wdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .info      (info)
  );

  // wave memory, registered read; writes and reads both issue at accept,
  // so a read always sees every earlier write
  bwt_wave_ram #(
    .MEM_AW (MEM_AW)
  ) u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_ch.wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result slot: scales the fetched nibble and holds the output level
  bwt_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .info_in   (info),
    .mem_rdata (mem_rdata),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .rdata     (out_ch.rdata),
    .level     (out_ch.level),
    .active    (out_ch.active)
  );

endmodule

// ----- bench/wave_channel_checker.sv -----
module wave_channel_checker (
  input  logic clk,
  input  logic rst_n,
  bwt_in_if    in_mon,
  bwt_out_if   out_mon,
  output int   fail_count,
  output int   outstanding
);
  import bwt_pkg::*;

  typedef struct packed {
    logic [7:0] rdata;
    logic [7:0] level;
    logic       active;
  } chan_out_t;

  chan_out_t queued_outputs[$];
  int        errors;

  // shadow of the channel state
  logic [7:0]          wave_mem [0:2*BANK_BYTES_DEF-1];
  logic [7:0]          ctrl_lo_reg;
  logic [15:0]         len_vol_reg;
  logic [15:0]         freq_reg;
  logic                playing;
  logic                bank;
  logic                two_bank;
  logic                may_en;
  logic [LEN_W-1:0]    len_left;
  logic                len_on;
  logic [PERIOD_W-1:0] period_left;
  logic [4:0]          nib_idx;
  logic [1:0]          vol;
  logic [7:0]          level_reg;

  function automatic logic [PERIOD_W-1:0] reload_ticks(input logic [15:0] f);
    return PERIOD_W'((2048 - int'(f[10:0])) * 8);
  endfunction

  task automatic halt();
    playing   = 1'b0;
    level_reg = 8'd0;
  endtask

  task automatic apply_command(input logic [1:0] c, input logic [5:0] a,
                               input logic [7:0] d, output chan_out_t res);
    logic [7:0] rd_byte;
    logic [7:0] b;
    logic [3:0] s;
    logic       in_wave;
    rd_byte = 8'd0;
    in_wave = int'(a) >= WAVE_BASE && int'(a) < WAVE_BASE + BANK_BYTES_DEF;
    case (cmd_t'(c))
      CMD_TICK: begin
        if (playing) begin
          if (period_left <= PERIOD_W'(1)) begin
            period_left = reload_ticks(freq_reg);
            b = wave_mem[{bank, nib_idx[4:1]}];
            s = nib_idx[0] ? b[3:0] : b[7:4];
            case (vol)
              VOL_MUTE:    s = 4'd0;
              VOL_HALF:    s = s >> 1;
              VOL_QUARTER: s = s >> 2;
              default: ;
            endcase
            level_reg = {s, 4'b0000};
            nib_idx = nib_idx + 5'd1;
            if (nib_idx == 5'd0 && two_bank) bank = ~bank;
          end else begin
            period_left = period_left - PERIOD_W'(1);
          end
        end
      end
      CMD_WRITE: begin
        if (in_wave) begin
          wave_mem[{~bank, a[3:0]}] = d;
        end else begin
          case (a)
            ADDR_CTRL_LO: begin
              ctrl_lo_reg = d;
              two_bank    = d[5];
              bank        = d[6];
              may_en      = d[7];
              if (!d[7]) halt();
            end
            ADDR_LEN_LO: len_vol_reg[7:0] = d;
            ADDR_LEN_HI: begin
              len_vol_reg[15:8] = d;
              len_left = 9'd256 - {1'b0, len_vol_reg[7:0]};
              vol = len_vol_reg[15] ? VOL_FULL : len_vol_reg[14:13];
            end
            ADDR_FREQ_LO: freq_reg[7:0] = d;
            ADDR_FREQ_HI: begin
              freq_reg[15:8] = d;
              if (d[7] && may_en) begin
                playing = 1'b1;
                if (len_left == '0) len_left = 9'd256;
                period_left = reload_ticks(freq_reg);
                nib_idx     = 5'd0;
                bank        = ctrl_lo_reg[6];
                len_on      = freq_reg[14];
              end
            end
            default: ;
          endcase
        end
      end
      CMD_READ: begin
        if (in_wave) begin
          rd_byte = wave_mem[{~bank, a[3:0]}];
        end else begin
          case (a)
            ADDR_CTRL_LO: rd_byte = ctrl_lo_reg & MASK_CTRL_LO;
            ADDR_LEN_HI:  rd_byte = len_vol_reg[15:8] & MASK_LEN_HI;
            ADDR_FREQ_HI: rd_byte = freq_reg[15:8] & MASK_FREQ_HI;
            default:      rd_byte = 8'd0;
          endcase
        end
      end
      default: begin
        if (len_on) begin
          if (len_left != '0) len_left = len_left - 9'd1;
          if (len_left == '0) halt();
        end
      end
    endcase
    res.rdata  = rd_byte;
    res.level  = playing ? level_reg : 8'd0;
    res.active = playing;
  endtask

  task automatic report(input string field, input logic [7:0] exp_v, input logic [7:0] act_v);
    $display("%0t wave chk: %s mismatch, expected %02h actual %02h", $time, field, exp_v, act_v);
    errors++;
  endtask

  always @(posedge clk) begin
    chan_out_t want;
    chan_out_t got;
    if (!rst_n) begin
      queued_outputs.delete();
      errors = 0;
      for (int i = 0; i < 2*BANK_BYTES_DEF; i++) wave_mem[i] = 8'd0;
      ctrl_lo_reg = '0;
      len_vol_reg = '0;
      freq_reg    = '0;
      playing     = 1'b0;
      bank        = 1'b0;
      two_bank    = 1'b0;
      may_en      = 1'b0;
      len_left    = '0;
      len_on      = 1'b0;
      period_left = '0;
      nib_idx     = '0;
      vol         = VOL_MUTE;
      level_reg   = '0;
    end else begin
      // results first: one offered now belongs to an earlier item
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.rdata, out_mon.level, out_mon.active};
        if (queued_outputs.size() == 0) begin
          $display("%0t wave chk: result with no item pending, actual %02h %02h %0b",
                   $time, got.rdata, got.level, got.active);
          errors++;
        end else begin
          want = queued_outputs.pop_front();
          if (got.rdata !== want.rdata) report("rdata", want.rdata, got.rdata);
          if (got.level !== want.level) report("level", want.level, got.level);
          if (got.active !== want.active)
            report("active", {7'd0, want.active}, {7'd0, got.active});
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        apply_command(in_mon.cmd, in_mon.addr, in_mon.wdata, want);
        queued_outputs.push_back(want);
      end
    end
    fail_count  <= errors;
    outstanding <= queued_outputs.size();
  end

endmodule

// ----- bench/testbench.sv -----
module testbench;
  import bwt_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEM_TARGET = 1400;
  // long result stall once this many items have gone in
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;

  localparam logic [5:0] WAVE_ADDR   = 6'(WAVE_BASE);
  localparam logic [5:0] ADDR_HOLE   = 6'd1;   // unmapped control byte
  localparam logic [5:0] ADDR_LAST   = 6'd63;  // top of the offset range, unmapped

  logic clk;
  logic rst_n;

  bwt_in_if  in_ch ();
  bwt_out_if out_ch ();

  int fail_count;
  int outstanding;
  int items_sent;
  int cycle_count;
  bit no_gaps;
  bit held_off;

  banked_wave_table_channel u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // watches both channels, predicts every result and compares
  wave_channel_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog on a hung handshake
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one item; returns at the edge where it is accepted
  // valid stays high into the next item when there is no gap
  task automatic send(input cmd_t c, input logic [5:0] a, input logic [7:0] d);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= c;
    in_ch.addr  <= a;
    in_ch.wdata <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wr(input logic [5:0] a, input logic [7:0] d);
    send(CMD_WRITE, a, d);
  endtask

  task automatic rd(input logic [5:0] a);
    send(CMD_READ, a, 8'($urandom));
  endtask

  // address and data of a tick carry random junk
  task automatic tick();
    send(CMD_TICK, 6'($urandom), 8'($urandom));
  endtask

  // result side: random ready, one long hold-off so the block backs up
  initial begin : result_drain
    int run;
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held_off && items_sent >= HOLD_AT) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      run = $urandom_range(1, 30);
      repeat (run) @(posedge clk);
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] v;
    int n;
    int r;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.cmd   <= CMD_TICK;
    in_ch.addr  <= '0;
    in_ch.wdata <= '0;
    items_sent  = 0;
    cycle_count = 0;
    no_gaps     = 1'b0;
    held_off    = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // reads straight after reset, including unmapped and write-only bytes
    rd(ADDR_CTRL_LO);
    rd(WAVE_ADDR);
    rd(ADDR_LAST);
    rd(ADDR_LEN_LO);
    // writes to unmapped offsets are dropped
    wr(ADDR_HOLE, 8'hFF);
    wr(ADDR_LAST, 8'hFF);
    // bank 0 plays after reset, so this lands in bank 1
    wr(WAVE_ADDR, 8'hF0);
    rd(WAVE_ADDR);
    // enable, two-bank mode, play bank 1
    wr(ADDR_CTRL_LO, 8'hE0);
    // length of one, bit 15 forces full volume
    wr(ADDR_LEN_LO, 8'hFF);
    wr(ADDR_LEN_HI, 8'hFF);
    // shortest period, length counter on, trigger
    wr(ADDR_FREQ_LO, 8'hFF);
    wr(ADDR_FREQ_HI, 8'hC7);
    repeat (8) tick();
    // length expiry stops the channel, then a tick while stopped
    send(CMD_LEN, 6'($urandom), 8'($urandom));
    tick();
    // longest period, zero length reloads to 256
    wr(ADDR_FREQ_LO, 8'h00);
    wr(ADDR_FREQ_HI, 8'h80);
    rd(ADDR_FREQ_HI);
    // clearing the enable bit stops playback
    wr(ADDR_CTRL_LO, 8'h00);

    // --- random part ---
    while (items_sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) != 0) begin
        // well-formed play session with random content
        v = 8'($urandom);
        if ($urandom_range(0, 9) != 0) v[7] = 1'b1;
        wr(ADDR_CTRL_LO, v);
        n = $urandom_range(0, 16);
        repeat (n) wr(6'(WAVE_BASE + $urandom_range(0, 15)), 8'($urandom));
        // short lengths now and then so the counter runs out
        if ($urandom_range(0, 9) < 3) wr(ADDR_LEN_LO, 8'($urandom_range(252, 255)));
        else                          wr(ADDR_LEN_LO, 8'($urandom));
        wr(ADDR_LEN_HI, 8'($urandom));
        if ($urandom_range(0, 9) != 0) wr(ADDR_FREQ_LO, 8'($urandom_range(248, 255)));
        else                           wr(ADDR_FREQ_LO, 8'($urandom));
        // short periods keep nibbles and bank wraps coming
        v = 8'($urandom);
        if ($urandom_range(0, 19) != 0) v[2:0] = 3'b111;
        if ($urandom_range(0, 9) != 0)  v[7]   = 1'b1;
        wr(ADDR_FREQ_HI, v);
        n = $urandom_range(40, 320);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 4) begin
            send(CMD_LEN, 6'($urandom), 8'($urandom));
          end else if (r < 8) begin
            if ($urandom_range(0, 9) < 6) rd(6'(WAVE_BASE + $urandom_range(0, 15)));
            else                          rd(6'($urandom));
          end else if (r < 10) begin
            wr(6'(WAVE_BASE + $urandom_range(0, 15)), 8'($urandom));
          end else if (r < 11) begin
            // control write mid-play: may stop or retrigger
            wr(6'($urandom_range(0, 5)), 8'($urandom));
          end else begin
            tick();
          end
        end
      end else begin
        // noise across every command and offset
        n = $urandom_range(4, 16);
        repeat (n) send(cmd_t'($urandom_range(0, 3)), 6'($urandom), 8'($urandom));
      end
    end

    // drain and give the verdict
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
